// File: rtl/mfr_pkg.sv
// Package for the message fragment reassembler: widths, codes and defaults.
`default_nettype none
package mfr_pkg;

  localparam int BUFFER_BYTES_DEF = 4096;

  localparam int CNT_W    = 13;
  localparam int TOTAL_W  = 16;
  localparam int OPC_W    = 4;
  localparam int HOP_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int RIDX_W   = 12;
  localparam int S_DATA_W = 72;
  localparam int M_DATA_W = 24;
  localparam int PADDR_W  = 3;

  localparam logic [CNT_W-1:0] TEXT_LIMIT_RST   = 13'd1024;
  localparam logic [CNT_W-1:0] BINARY_LIMIT_RST = 13'd4096;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [OPC_W-1:0] {
    OP_CONT   = 4'd0,
    OP_TEXT   = 4'd1,
    OP_BINARY = 4'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_COMPLETE  = 3'd1,
    ST_MALFORMED = 3'd2,
    ST_TOO_LARGE = 3'd3,
    ST_INVALID   = 3'd4
  } status_t;

  typedef enum logic {
    REG_TEXT_LIMIT   = 1'b0,
    REG_BINARY_LIMIT = 1'b1
  } reg_idx_t;

endpackage
`default_nettype wire

// File: rtl/message_fragment_reassembler.sv
// Message fragment reassembler: tracker, message buffer memory and output stages.
//
// Input words carry a chunk header, a payload byte or a buffer read, selected by
// s_tuser. Every accepted word produces exactly one result word on the master side,
// in order: a status in m_tuser and the message size, opcode and read byte in m_tdata.
// Throughput is one word per cycle while the receiver keeps up. A result passes through
// the synchronous read of the message buffer memory and then the output register. The
// tracker counters sit in flip-flops and are updated in the accept cycle, so consecutive
// words never wait on each other.
// When the receiver stalls, the output register holds its word and one more result
// is absorbed in the memory read stage; after that s_tready falls until m_tready
// returns. Reset clears the tracker and restores the limits to 1024 and 4096 bytes;
// s_tready stays low while reset is held. The buffer contents are not cleared and a
// byte reads back only once written.
// Both limits are written through the APB port at byte addresses 0 and 4 and are
// used clamped to the buffer depth.
`default_nettype none
module message_fragment_reassembler #(
  parameter int BUFFER_BYTES = mfr_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output      logic                          s_tready,
  // frame_opcode, total_size, chunk_offset, chunk_length, data_byte, read_index
  input  wire logic [mfr_pkg::S_DATA_W-1:0]  s_tdata,
  // kind
  input  wire logic [1:0]                    s_tuser,
  // final_flag
  input  wire logic                          s_tlast,
  output      logic                          m_tvalid,
  input  wire logic                          m_tready,
  // message_size, message_opcode, read_data
  output      logic [mfr_pkg::M_DATA_W-1:0]  m_tdata,
  // status
  output      logic [2:0]                    m_tuser,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mfr_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output      logic [31:0]                   prdata,
  output      logic                          pready
);
  import mfr_pkg::*;

  localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam logic [16:0] BUF_LIM = 17'(BUFFER_BYTES);

  logic [CNT_W-1:0] text_limit;
  logic [CNT_W-1:0] binary_limit;

  logic [CNT_W-1:0] expected_total, expected_total_next;
  logic [CNT_W-1:0] received_count, received_count_next;
  logic [HOP_W-1:0] held_opcode, held_opcode_next;
  logic             assembling, assembling_next;
  logic [CNT_W-1:0] chunk_left, chunk_left_next;
  logic             chunk_final, chunk_final_next;

  logic [BYTE_W-1:0] buffer_mem [BUFFER_BYTES];
  logic [BYTE_W-1:0] rd_data;

  logic                accept;
  kind_t               kind;
  logic [OPC_W-1:0]    frame_opcode;
  logic [TOTAL_W-1:0]  total_size;
  logic [TOTAL_W-1:0]  chunk_offset;
  logic [CNT_W-1:0]    chunk_length;
  logic [BYTE_W-1:0]   data_byte;
  logic [RIDX_W-1:0]   read_index;

  status_t           res_status;
  logic [CNT_W-1:0]  res_size;
  logic [HOP_W-1:0]  res_op;
  logic              wr_en;
  logic              rd_en;
  logic [16:0]       lim;
  logic [CNT_W-1:0]  base_total;
  logic [CNT_W-1:0]  base_recv;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  left_dec;

  logic              s1_valid;
  status_t           s1_status;
  logic [CNT_W-1:0]  s1_size;
  logic [HOP_W-1:0]  s1_op;
  logic              s1_rd;
  logic              s1_adv;

  logic              out_valid;
  status_t           out_status;
  logic [CNT_W-1:0]  out_size;
  logic [HOP_W-1:0]  out_op;
  logic [BYTE_W-1:0] out_rdata;

  assign kind         = kind_t'(s_tuser);
  assign frame_opcode = s_tdata[3:0];
  assign total_size   = s_tdata[19:4];
  assign chunk_offset = s_tdata[35:20];
  assign chunk_length = s_tdata[48:36];
  assign data_byte    = s_tdata[56:49];
  assign read_index   = s_tdata[68:57];

  assign s1_adv   = s1_valid && (!out_valid || m_tready);
  assign s_tready = !rst && (!s1_valid || s1_adv);
  assign accept   = s_tvalid && s_tready;

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_limit   <= TEXT_LIMIT_RST;
      binary_limit <= BINARY_LIMIT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_TEXT_LIMIT:   text_limit   <= pwdata[CNT_W-1:0];
        REG_BINARY_LIMIT: binary_limit <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_TEXT_LIMIT:   prdata = {{(32-CNT_W){1'b0}}, text_limit};
      REG_BINARY_LIMIT: prdata = {{(32-CNT_W){1'b0}}, binary_limit};
      default:          prdata = '0;
    endcase
  end

  // Tracker update for the accepted word
  always_comb begin
    expected_total_next = expected_total;
    received_count_next = received_count;
    held_opcode_next    = held_opcode;
    assembling_next     = assembling;
    chunk_left_next     = chunk_left;
    chunk_final_next    = chunk_final;
    res_status          = ST_OK;
    res_size            = '0;
    res_op              = '0;
    wr_en               = 1'b0;
    rd_en               = 1'b0;
    base_total          = expected_total;
    base_recv           = received_count;
    cnt_inc             = received_count + 1'b1;
    left_dec            = chunk_left - 1'b1;
    lim = (frame_opcode == OP_TEXT) ? {4'd0, text_limit} : {4'd0, binary_limit};
    if (lim > BUF_LIM) begin
      lim = BUF_LIM;
    end

    unique case (kind)
      KIND_HEADER: begin
        if (chunk_offset == '0) begin
          base_total = total_size[CNT_W-1:0];
          base_recv  = '0;
          if (frame_opcode != OP_TEXT && frame_opcode != OP_BINARY) begin
            res_status = ST_MALFORMED;
          end else if (total_size == '0 || {1'b0, total_size} > lim) begin
            res_status = ST_TOO_LARGE;
          end
        end else if (!assembling ||
                     (frame_opcode != OP_CONT &&
                      frame_opcode != {{(OPC_W-HOP_W){1'b0}}, held_opcode}) ||
                     total_size != {{(TOTAL_W-CNT_W){1'b0}}, expected_total} ||
                     chunk_offset != {{(TOTAL_W-CNT_W){1'b0}}, received_count}) begin
          res_status = ST_MALFORMED;
        end
        if (res_status == ST_OK &&
            (chunk_length == '0 || chunk_length > (base_total - base_recv))) begin
          res_status = ST_MALFORMED;
        end
        if (res_status == ST_OK) begin
          if (chunk_offset == '0) begin
            expected_total_next = base_total;
            received_count_next = '0;
            held_opcode_next    = frame_opcode[HOP_W-1:0];
            assembling_next     = 1'b1;
          end
          chunk_left_next  = chunk_length;
          chunk_final_next = s_tlast;
        end else begin
          expected_total_next = '0;
          received_count_next = '0;
          held_opcode_next    = '0;
          assembling_next     = 1'b0;
          chunk_left_next     = '0;
          chunk_final_next    = 1'b0;
        end
      end
      KIND_DATA: begin
        if (!assembling || chunk_left == '0) begin
          res_status = ST_INVALID;
        end else begin
          wr_en               = ({4'd0, received_count} < BUF_LIM);
          received_count_next = cnt_inc;
          chunk_left_next     = left_dec;
          if (left_dec == '0 && cnt_inc >= expected_total) begin
            if (chunk_final) begin
              res_status = ST_COMPLETE;
              res_size   = cnt_inc;
              res_op     = held_opcode;
            end else begin
              res_status = ST_MALFORMED;
            end
            expected_total_next = '0;
            received_count_next = '0;
            held_opcode_next    = '0;
            assembling_next     = 1'b0;
            chunk_left_next     = '0;
            chunk_final_next    = 1'b0;
          end
        end
      end
      KIND_READ: begin
        rd_en = ({5'd0, read_index} < BUF_LIM);
      end
      default: begin
        res_status = ST_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_total <= '0;
      received_count <= '0;
      held_opcode    <= '0;
      assembling     <= 1'b0;
      chunk_left     <= '0;
      chunk_final    <= 1'b0;
    end else if (accept) begin
      expected_total <= expected_total_next;
      received_count <= received_count_next;
      held_opcode    <= held_opcode_next;
      assembling     <= assembling_next;
      chunk_left     <= chunk_left_next;
      chunk_final    <= chunk_final_next;
    end
  end

  // Message buffer
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      buffer_mem[AW'(received_count)] <= data_byte;
    end
    if (accept && rd_en) begin
      rd_data <= buffer_mem[AW'(read_index)];
    end
  end

  // Memory read stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= res_status;
      s1_size   <= res_size;
      s1_op     <= res_op;
      s1_rd     <= rd_en;
    end
    if (s1_adv) begin
      out_status <= s1_status;
      out_size   <= s1_size;
      out_op     <= s1_op;
      out_rdata  <= s1_rd ? rd_data : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {{(M_DATA_W-CNT_W-HOP_W-BYTE_W){1'b0}}, out_rdata, out_op, out_size};

endmodule
`default_nettype wire

// File: bench/message_fragment_reassembler_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the message fragment reassembler with a scoreboard class.
module message_fragment_reassembler_tb;
  import mfr_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [12:0] size;
    logic [1:0]  opcode;
    logic [7:0]  rdata;
  } reasm_result_t;

  class reassembly_scoreboard;
    int unsigned   text_limit;
    int unsigned   binary_limit;
    int unsigned   msg_total;
    int unsigned   rx_count;
    logic [3:0]    held_op;
    bit            assembling;
    int unsigned   chunk_left;
    bit            chunk_fin;
    logic [7:0]    payload [BUFFER_BYTES_DEF];
    bit            written [BUFFER_BYTES_DEF];
    bit            any_written;
    int unsigned   last_written;
    reasm_result_t expected_q [$];
    int            errors;

    function new();
      text_limit = 32'(TEXT_LIMIT_RST);
      binary_limit = 32'(BINARY_LIMIT_RST);
      any_written = 1'b0;
      last_written = 0;
      errors = 0;
      clear_tracker();
    endfunction

    function void clear_tracker();
      msg_total = 0;
      rx_count = 0;
      held_op = OP_CONT;
      assembling = 1'b0;
      chunk_left = 0;
      chunk_fin = 1'b0;
    endfunction

    function int unsigned limit_for(logic [3:0] op);
      int unsigned lim;
      lim = (op == OP_TEXT) ? text_limit : binary_limit;
      return (lim > BUFFER_BYTES_DEF) ? BUFFER_BYTES_DEF : lim;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_word(logic [1:0] kind, logic [S_DATA_W-1:0] data, logic fin);
      logic [3:0]    op;
      int unsigned   total;
      int unsigned   offset;
      int unsigned   len;
      logic [11:0]   ridx;
      reasm_result_t res;
      op = data[3:0];
      total = 32'(data[19:4]);
      offset = 32'(data[35:20]);
      len = 32'(data[48:36]);
      ridx = data[68:57];
      res = '0;
      case (kind)
        KIND_HEADER: begin
          if (offset == 0) begin
            if (op != OP_TEXT && op != OP_BINARY) begin
              res.status = ST_MALFORMED;
            end else if (total == 0 || total > limit_for(op)) begin
              res.status = ST_TOO_LARGE;
            end else begin
              msg_total = total;
              rx_count = 0;
              held_op = op;
              assembling = 1'b1;
            end
          end else if (!assembling || (op != OP_CONT && op != held_op) ||
                       total != msg_total || offset != rx_count) begin
            res.status = ST_MALFORMED;
          end
          if (res.status == ST_OK && (len == 0 || len > msg_total - rx_count))
            res.status = ST_MALFORMED;
          if (res.status == ST_OK) begin
            chunk_left = len;
            chunk_fin = fin;
          end else begin
            clear_tracker();
          end
        end
        KIND_DATA: begin
          if (!assembling || chunk_left == 0) begin
            res.status = ST_INVALID;
          end else begin
            payload[rx_count] = data[56:49];
            written[rx_count] = 1'b1;
            any_written = 1'b1;
            last_written = rx_count;
            rx_count++;
            chunk_left--;
            if (chunk_left == 0 && rx_count >= msg_total) begin
              if (chunk_fin) begin
                res.status = ST_COMPLETE;
                res.size = 13'(rx_count);
                res.opcode = held_op[1:0];
              end else begin
                res.status = ST_MALFORMED;
              end
              clear_tracker();
            end
          end
        end
        KIND_READ: res.rdata = payload[ridx];
        default: res.status = ST_INVALID;
      endcase
      expected_q.push_back(res);
    endfunction

    function void mismatch(string field, int unsigned want, int unsigned seen);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
    endfunction

    function void check_result(logic [2:0] status, logic [M_DATA_W-1:0] data);
      reasm_result_t want;
      if (expected_q.size() == 0) begin
        mismatch("unexpected result word, status", 0, 32'(status));
        return;
      end
      want = expected_q.pop_front();
      if (status !== want.status)
        mismatch("status", 32'(want.status), 32'(status));
      if (data[12:0] !== want.size)
        mismatch("message_size", 32'(want.size), 32'(data[12:0]));
      if (data[14:13] !== want.opcode)
        mismatch("message_opcode", 32'(want.opcode), 32'(data[14:13]));
      if (data[22:15] !== want.rdata)
        mismatch("read_data", 32'(want.rdata), 32'(data[22:15]));
    endfunction
  endclass

  localparam int IDLE_LIMIT  = 5000;
  localparam int HOLD_CYCLES = 150;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic [1:0]          s_tuser;
  logic                s_tlast;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;
  logic [2:0]          m_tuser;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  reassembly_scoreboard sb;
  bit tx_calm;
  bit no_idle;
  bit hold_req;
  int sent_words;
  int idle_cycles;

  message_fragment_reassembler DUT (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_word(s_tuser, s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  // The receiver alternates ready runs and stalls; a hold request forces one long stall.
  initial begin
    int left;
    bit ready;
    m_tready = 1'b0;
    left = 0;
    ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        ready = 1'b0;
        left = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (left == 0) begin
        ready = no_idle || $urandom_range(0, 2) != 0;
        if (ready)
          left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
        else
          left = $urandom_range(1, 13);
      end
      m_tready <= ready;
      left--;
    end
  end

  task automatic send_word(kind_t kind, logic [3:0] op, logic [15:0] total,
                           logic [15:0] offset, logic fin, logic [12:0] len,
                           logic [7:0] dbyte);
    logic [11:0] ridx;
    int gap;
    if (!no_idle && !tx_calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    ridx = 12'($urandom_range(0, BUFFER_BYTES_DEF - 1));
    if (kind == KIND_READ && !sb.written[ridx]) ridx = 12'(sb.last_written);
    s_tdata <= {3'b000, ridx, dbyte, len, offset, total, op};
    s_tuser <= kind;
    s_tlast <= fin;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (kind != KIND_NONE) sent_words++;
  endtask

  task automatic send_header(logic [3:0] op, int unsigned total, int unsigned offset,
                             logic fin, int unsigned len);
    send_word(KIND_HEADER, op, 16'(total), 16'(offset), fin, 13'(len), 8'($urandom));
  endtask

  task automatic send_data();
    send_word(KIND_DATA, 4'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
              13'($urandom_range(0, 4096)), 8'($urandom));
  endtask

  task automatic send_read();
    if (sb.any_written)
      send_word(KIND_READ, 4'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                13'($urandom_range(0, 4096)), 8'($urandom));
  endtask

  task automatic apb_write(reg_idx_t idx, int unsigned value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(int'(idx) * 4);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_limits(int unsigned text_lim, int unsigned bin_lim);
    drain();
    apb_write(REG_TEXT_LIMIT, text_lim);
    apb_write(REG_BINARY_LIMIT, bin_lim);
    sb.text_limit = text_lim;
    sb.binary_limit = bin_lim;
  endtask

  // A message split into chunks, now and then with one flaw in a chunk header or a chunk cut short of its bytes.
  task automatic run_message();
    logic [3:0]  op;
    logic [3:0]  hop;
    int unsigned lim;
    int unsigned cap;
    int unsigned total;
    int unsigned total_sent;
    int unsigned got;
    int unsigned remaining;
    int unsigned len;
    int unsigned offset;
    int unsigned n;
    int          flaw;
    bit          fin;
    op = $urandom_range(0, 1) ? OP_TEXT : OP_BINARY;
    lim = sb.limit_for(op);
    cap = (lim < 24) ? lim : 24;
    if ($urandom_range(0, 7) == 0) cap = (lim < 200) ? lim : 200;
    total = $urandom_range(1, cap);
    if (lim <= 200 && $urandom_range(0, 15) == 0) total = lim;
    got = 0;
    while (got < total) begin
      remaining = total - got;
      len = ($urandom_range(0, 2) == 0) ? remaining : $urandom_range(1, remaining);
      fin = (got + len == total);
      hop = (got == 0 || $urandom_range(0, 1)) ? op : OP_CONT;
      offset = got;
      total_sent = total;
      flaw = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 6) : 0;
      case (flaw)
        1: offset = got + 1;
        2: total_sent = total + 1;
        3: fin = !fin;
        4: len = remaining + 1;
        5: hop = (got == 0) ? 4'($urandom_range(3, 15)) :
                 ((op == OP_TEXT) ? OP_BINARY : OP_TEXT);
        default: ;
      endcase
      send_header(hop, total_sent, offset, fin, len);
      n = (flaw == 6) ? $urandom_range(0, len - 1) : len;
      if (flaw inside {1, 2, 4, 5}) n = $urandom_range(0, 2);
      repeat (n) begin
        if ($urandom_range(0, 15) == 0) send_read();
        send_data();
      end
      if (flaw != 0 && flaw != 3) return;
      got += len;
    end
  endtask

  task automatic noise_word();
    int unsigned lim;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: send_header(4'($urandom),
                              $urandom_range(0, 1) ? $urandom_range(0, 65535) :
                                                     $urandom_range(0, 64),
                              $urandom_range(0, 1) ? 0 : $urandom_range(0, 65535),
                              1'($urandom), $urandom_range(0, 4096));
      4, 5: send_data();
      6, 7: send_read();
      8: send_word(KIND_NONE, 4'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                   13'($urandom_range(0, 4096)), 8'($urandom));
      default: begin
        lim = sb.limit_for(OP_BINARY);
        send_header(OP_BINARY, lim + $urandom_range(0, 1), 0, 1'($urandom),
                    $urandom_range(1, 4));
      end
    endcase
  endtask

  task automatic run_traffic(int words);
    int stop;
    stop = sent_words + words;
    while (sent_words < stop) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) noise_word();
      else run_message();
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = KIND_HEADER;
    s_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_cycles = 0;
    sent_words = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_data();
    send_word(KIND_NONE, 4'($urandom), 16'($urandom), 16'($urandom), 1'b1, 13'd0, 8'hFF);
    send_header(4'($urandom_range(3, 15)), 10, 0, 1'b1, 10);
    send_header(OP_TEXT, 0, 0, 1'b1, 1);
    send_header(OP_TEXT, TEXT_LIMIT_RST + 1, 0, 1'b1, 1);
    send_header(OP_CONT, 3, 5, 1'b1, 1);
    send_header(OP_BINARY, 3, 0, 1'b1, 0);
    send_header(OP_BINARY, 3, 0, 1'b1, 4);
    send_header(OP_TEXT, 3, 0, 1'b0, 2);
    send_data();
    send_data();
    send_header(OP_CONT, 3, 2, 1'b1, 1);
    send_data();
    send_read();
    send_header(OP_BINARY, 2, 0, 1'b0, 2);
    send_data();
    send_data();
    send_header(OP_TEXT, 4, 0, 1'b1, 4);
    send_data();
    send_header(OP_BINARY, 1, 0, 1'b1, 1);
    send_data();
    send_header(OP_TEXT, 4, 0, 1'b0, 2);
    send_data();
    send_data();
    send_header(OP_BINARY, 4, 2, 1'b1, 2);
    send_header(4'hF, 16'hFFFF, 16'hFFFF, 1'b1, 4096);

    set_limits(1, 1);
    send_header(OP_TEXT, 1, 0, 1'b1, 1);
    send_data();
    send_header(OP_TEXT, 2, 0, 1'b1, 2);
    send_header(OP_BINARY, 2, 0, 1'b1, 1);
    send_header(OP_BINARY, 1, 0, 1'b1, 1);
    send_data();
    send_read();
    run_traffic(80);

    // A message of the full buffer depth is opened and one byte more is refused.
    set_limits(BUFFER_BYTES_DEF, BUFFER_BYTES_DEF);
    tx_calm = 1'b0;
    send_header(OP_BINARY, BUFFER_BYTES_DEF, 0, 1'b1, BUFFER_BYTES_DEF);
    repeat (20) send_data();
    send_read();
    send_header(OP_TEXT, BUFFER_BYTES_DEF + 1, 0, 1'b1, 1);
    send_header(OP_TEXT, BUFFER_BYTES_DEF, 0, 1'b1, BUFFER_BYTES_DEF);
    run_traffic(180);

    for (int p = 0; p < 3; p++) begin
      set_limits($urandom_range(0, 1) ? $urandom_range(1, 48) : $urandom_range(1, 4096),
                 $urandom_range(0, 1) ? $urandom_range(1, 48) : $urandom_range(1, 4096));
      if (p == 1) begin
        hold_req = 1'b1;
        tx_calm = 1'b1;
        repeat (6) run_message();
      end
      run_traffic(180);
    end

    set_limits(BUFFER_BYTES_DEF, 1);
    run_traffic(80);

    set_limits($urandom_range(1, 64), $urandom_range(1, 64));
    no_idle = 1'b1;
    run_traffic(120);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
